FILE: hw/rtl/mmqe_pkg.sv
// types and constants shared by the quote engine files
package mmqe_pkg;

  // internal price fraction: every price term is held with this many fraction bits
  localparam int IFRAC = 25;

  // configuration register indexes
  localparam logic [2:0] CFG_PRICING_MODE      = 3'd0;
  localparam logic [2:0] CFG_FIXED_HALF_SPREAD = 3'd1;
  localparam logic [2:0] CFG_QUOTE_SIZE        = 3'd2;
  localparam logic [2:0] CFG_MAX_INVENTORY     = 3'd3;
  localparam logic [2:0] CFG_SKEW_PER_UNIT     = 3'd4;
  localparam logic [2:0] CFG_RISK_COEFFICIENT  = 3'd5;
  localparam logic [2:0] CFG_SPREAD_FLOOR_TERM = 3'd6;
  localparam logic [2:0] CFG_HORIZON           = 3'd7;

  // pricing modes (the unused code behaves as fixed spread)
  localparam logic [1:0] MODE_FIXED = 2'd0;
  localparam logic [1:0] MODE_SKEW  = 2'd1;
  localparam logic [1:0] MODE_AS    = 2'd2;

  // input item
  typedef struct packed {
    logic        [31:0] mid_px;
    logic signed [23:0] inventory;
    logic        [31:0] now_time;
  } quote_in_t;

  // result item
  typedef struct packed {
    logic signed [31:0] bid_price;
    logic signed [31:0] ask_price;
    logic               bid_enable;
    logic               ask_enable;
    logic        [31:0] quote_quantity;
  } quote_out_t;

  // configuration register contents
  typedef struct packed {
    logic [1:0]  pricing_mode;
    logic [15:0] fixed_half_spread;
    logic [31:0] quote_size;
    logic [22:0] max_inventory;
    logic [23:0] skew_per_unit;
    logic [23:0] risk_coefficient;
    logic [23:0] spread_floor_term;
    logic [31:0] horizon;
  } cfg_t;

endpackage

FILE: hw/rtl/mmqe_cfg_regs.sv
// configuration register file of the quote engine
module mmqe_cfg_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  output mmqe_pkg::cfg_t     cfg_o
);

  mmqe_pkg::cfg_t cfg_q, cfg_d;

  // write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mmqe_pkg::CFG_PRICING_MODE:      cfg_d.pricing_mode      = cfg_wdata_i[1:0];
        mmqe_pkg::CFG_FIXED_HALF_SPREAD: cfg_d.fixed_half_spread = cfg_wdata_i[15:0];
        mmqe_pkg::CFG_QUOTE_SIZE:        cfg_d.quote_size        = cfg_wdata_i;
        mmqe_pkg::CFG_MAX_INVENTORY:     cfg_d.max_inventory     = cfg_wdata_i[22:0];
        mmqe_pkg::CFG_SKEW_PER_UNIT:     cfg_d.skew_per_unit     = cfg_wdata_i[23:0];
        mmqe_pkg::CFG_RISK_COEFFICIENT:  cfg_d.risk_coefficient  = cfg_wdata_i[23:0];
        mmqe_pkg::CFG_SPREAD_FLOOR_TERM: cfg_d.spread_floor_term = cfg_wdata_i[23:0];
        mmqe_pkg::CFG_HORIZON:           cfg_d.horizon           = cfg_wdata_i;
      endcase
    end
  end

  // register bank with reset values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pricing_mode      <= mmqe_pkg::MODE_FIXED;
      cfg_q.fixed_half_spread <= 16'd1;
      cfg_q.quote_size        <= 32'd1;
      cfg_q.max_inventory     <= 23'd100;
      cfg_q.skew_per_unit     <= 24'd0;
      cfg_q.risk_coefficient  <= 24'd0;
      cfg_q.spread_floor_term <= 24'd0;
      cfg_q.horizon           <= 32'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/market_maker_quote_engine.sv
// market maker quote engine: eight stage quote pipeline with config registers
//
// Usage: each transfer on the input channel (in_valid_i / in_stall_o, payload
// in_data_i: mid price, signed inventory, current time) yields exactly one quote
// transfer on the output channel (out_valid_o / out_stall_i, payload out_data_o:
// bid, ask, side enables, quantity). Results leave in input order.
// Throughput is one item per cycle while the receiver does not stall. The
// stages in order are the time-left subtract, the 24x32 risk multiply, the
// split 24x56 skew multiply, its saturating sum, the reference update, the
// spread add, the floor/ceiling and the final cross check with 32-bit
// saturation, each taking one stage.
// Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_wdata_i),
// written while no items are in flight; registers take their documented
// values at reset.
// Reset (rst_ni low, asynchronous) empties the pipeline. When the receiver
// stalls, the result holds on out_data_o and earlier stages keep filling their
// empty slots; in_stall_o rises only once every stage holds an item.
module market_maker_quote_engine #(
  parameter int PRICE_FRAC_BITS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  mmqe_pkg::quote_in_t    in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output mmqe_pkg::quote_out_t   out_data_o,
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_idx_i,
  input  logic [31:0]            cfg_wdata_i
);

  localparam int NSTAGE   = 8;
  localparam int MID_SHL  = mmqe_pkg::IFRAC - PRICE_FRAC_BITS;
  localparam logic [56:0] HS_ONE   = 57'd1 << mmqe_pkg::IFRAC;
  localparam logic [60:0] PROD_MAX = 61'd1 << 60;
  localparam logic [63:0] CEIL_ADD = (64'd1 << mmqe_pkg::IFRAC) - 64'd1;

  mmqe_pkg::cfg_t cfg;

  mmqe_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // saturate a whole-tick price to 32-bit signed
  function automatic logic signed [31:0] sat32(input logic signed [38:0] v);
    logic signed [31:0] r;
    if (v > 39'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -39'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // pipeline flow control: a stage loads when empty or when its item moves on
  logic [NSTAGE-1:0] valid_q;
  logic [NSTAGE-1:0] load;

  always_comb begin
    load[NSTAGE-1] = !valid_q[NSTAGE-1] || !out_stall_i;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      load[k] = !valid_q[k] || load[k+1];
    end
  end

  assign in_stall_o = !load[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (load[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (load[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // stage 1: time left, inventory magnitude, side enables
  logic        [31:0] s1_mid_q, s1_tl_q;
  logic        [23:0] s1_mag_q;
  logic signed [23:0] s1_inv_q;
  logic               s1_bid_en_q, s1_ask_en_q;
  logic        [31:0] s1_tl_d;
  logic        [23:0] s1_mag_d;
  logic signed [23:0] max_inv_s;
  logic signed [24:0] neg_max_inv_s, inv_wide_s;

  always_comb begin
    s1_tl_d       = (cfg.horizon > in_data_i.now_time) ? cfg.horizon - in_data_i.now_time
                                                       : 32'd0;
    s1_mag_d      = in_data_i.inventory[23] ? (~in_data_i.inventory) + 24'd1
                                            : in_data_i.inventory;
    max_inv_s     = $signed({1'b0, cfg.max_inventory});
    neg_max_inv_s = $signed(25'd0 - {2'b00, cfg.max_inventory});
    inv_wide_s    = $signed({in_data_i.inventory[23], in_data_i.inventory});
  end

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      s1_mid_q    <= in_data_i.mid_px;
      s1_tl_q     <= s1_tl_d;
      s1_mag_q    <= s1_mag_d;
      s1_inv_q    <= in_data_i.inventory;
      s1_bid_en_q <= in_data_i.inventory < max_inv_s;
      s1_ask_en_q <= inv_wide_s > neg_max_inv_s;
    end
  end

  // stage 2: risk term and inventory skew products
  logic        [31:0] s2_mid_q;
  logic        [55:0] s2_term_q;
  logic signed [48:0] s2_skew_q;
  logic        [23:0] s2_mag_q;
  logic               s2_neg_q, s2_bid_en_q, s2_ask_en_q;
  logic signed [24:0] s2_inv_w, s2_spu_w;

  assign s2_inv_w = $signed({s1_inv_q[23], s1_inv_q});
  assign s2_spu_w = $signed({1'b0, cfg.skew_per_unit});

  always_ff @(posedge clk_i) begin
    if (load[1]) begin
      s2_mid_q    <= s1_mid_q;
      s2_term_q   <= {32'd0, cfg.risk_coefficient} * {24'd0, s1_tl_q};
      s2_skew_q   <= 49'(s2_inv_w * s2_spu_w);
      s2_mag_q    <= s1_mag_q;
      s2_neg_q    <= s1_inv_q[23];
      s2_bid_en_q <= s1_bid_en_q;
      s2_ask_en_q <= s1_ask_en_q;
    end
  end

  // stage 3: split skew multiply, half spread, base reference
  logic        [51:0] s3_pp_lo_q, s3_pp_hi_q;
  logic        [56:0] s3_hs_q;
  logic signed [63:0] s3_ref_q;
  logic               s3_neg_q, s3_bid_en_q, s3_ask_en_q;
  logic        [56:0] s3_hs_raw, s3_hs_d;
  logic        [15:0] s3_fh;
  logic signed [63:0] s3_mid_x, s3_ref_d;

  always_comb begin
    s3_fh = (cfg.fixed_half_spread == 16'd0) ? 16'd1 : cfg.fixed_half_spread;
    if (cfg.pricing_mode == mmqe_pkg::MODE_AS) begin
      // half of a 24-fraction value read with 25 fraction bits
      s3_hs_raw = {1'b0, s2_term_q} + {17'd0, cfg.spread_floor_term, 16'd0};
    end else begin
      s3_hs_raw = {16'd0, s3_fh, 25'd0};
    end
    s3_hs_d  = (s3_hs_raw < HS_ONE) ? HS_ONE : s3_hs_raw;
    s3_mid_x = $signed({32'd0, s2_mid_q} << MID_SHL);
    if (cfg.pricing_mode == mmqe_pkg::MODE_SKEW) begin
      s3_ref_d = s3_mid_x - ($signed({{15{s2_skew_q[48]}}, s2_skew_q}) <<< 9);
    end else begin
      s3_ref_d = s3_mid_x;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[2]) begin
      s3_pp_lo_q  <= {28'd0, s2_mag_q} * {24'd0, s2_term_q[27:0]};
      s3_pp_hi_q  <= {28'd0, s2_mag_q} * {24'd0, s2_term_q[55:28]};
      s3_hs_q     <= s3_hs_d;
      s3_ref_q    <= s3_ref_d;
      s3_neg_q    <= s2_neg_q;
      s3_bid_en_q <= s2_bid_en_q;
      s3_ask_en_q <= s2_ask_en_q;
    end
  end

  // stage 4: combine partial products, saturate at 2^60
  logic        [60:0] s4_prod_q;
  logic        [56:0] s4_hs_q;
  logic signed [63:0] s4_ref_q;
  logic               s4_neg_q, s4_bid_en_q, s4_ask_en_q;
  logic        [79:0] s4_sum;
  logic               s4_over;

  always_comb begin
    s4_sum  = {s3_pp_hi_q, 28'd0} + {28'd0, s3_pp_lo_q};
    s4_over = (|s4_sum[79:61]) || (s4_sum[60] && (|s4_sum[59:0]));
  end

  always_ff @(posedge clk_i) begin
    if (load[3]) begin
      s4_prod_q   <= s4_over ? PROD_MAX : s4_sum[60:0];
      s4_hs_q     <= s3_hs_q;
      s4_ref_q    <= s3_ref_q;
      s4_neg_q    <= s3_neg_q;
      s4_bid_en_q <= s3_bid_en_q;
      s4_ask_en_q <= s3_ask_en_q;
    end
  end

  // stage 5: shift the reference by the inventory risk term
  logic        [56:0] s5_hs_q;
  logic signed [63:0] s5_ref_q;
  logic               s5_bid_en_q, s5_ask_en_q;
  logic signed [63:0] s5_adj, s5_ref_d;

  always_comb begin
    s5_adj = $signed({2'b00, s4_prod_q, 1'b0});
    if (cfg.pricing_mode != mmqe_pkg::MODE_AS) begin
      s5_ref_d = s4_ref_q;
    end else if (s4_neg_q) begin
      s5_ref_d = s4_ref_q + s5_adj;
    end else begin
      s5_ref_d = s4_ref_q - s5_adj;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[4]) begin
      s5_hs_q     <= s4_hs_q;
      s5_ref_q    <= s5_ref_d;
      s5_bid_en_q <= s4_bid_en_q;
      s5_ask_en_q <= s4_ask_en_q;
    end
  end

  // stage 6: lower and upper quote edges
  logic signed [63:0] s6_lo_q, s6_hi_q;
  logic               s6_bid_en_q, s6_ask_en_q;
  logic signed [63:0] s6_hs_w;

  assign s6_hs_w = $signed({7'd0, s5_hs_q});

  always_ff @(posedge clk_i) begin
    if (load[5]) begin
      s6_lo_q     <= s5_ref_q - s6_hs_w;
      s6_hi_q     <= s5_ref_q + s6_hs_w;
      s6_bid_en_q <= s5_bid_en_q;
      s6_ask_en_q <= s5_ask_en_q;
    end
  end

  // stage 7: floor of the bid edge, ceiling of the ask edge
  logic signed [38:0] s7_bid_q, s7_ask_q;
  logic               s7_bid_en_q, s7_ask_en_q;
  logic        [63:0] s7_hi_up;

  assign s7_hi_up = s6_hi_q + CEIL_ADD;

  always_ff @(posedge clk_i) begin
    if (load[6]) begin
      s7_bid_q    <= s6_lo_q[63:25];
      s7_ask_q    <= $signed(s7_hi_up[63:25]);
      s7_bid_en_q <= s6_bid_en_q;
      s7_ask_en_q <= s6_ask_en_q;
    end
  end

  // stage 8: crossed quote fix, saturation, output register
  mmqe_pkg::quote_out_t out_q;
  logic signed [38:0]   s8_ask;

  assign s8_ask = (s7_ask_q <= s7_bid_q) ? s7_bid_q + 39'sd1 : s7_ask_q;

  always_ff @(posedge clk_i) begin
    if (load[7]) begin
      out_q.bid_price      <= sat32(s7_bid_q);
      out_q.ask_price      <= sat32(s8_ask);
      out_q.bid_enable     <= s7_bid_en_q;
      out_q.ask_enable     <= s7_ask_en_q;
      out_q.quote_quantity <= cfg.quote_size;
    end
  end

  assign out_valid_o = valid_q[NSTAGE-1];
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // input held off only when every stage is occupied
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&valid_q))
    else $error("input stalled with an empty stage");

  // ask never below bid on a valid result
  a_ask_ge_bid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.ask_price >= out_data_o.bid_price))
    else $error("ask below bid");

  // risk product stays within its saturation limit
  a_prod_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[3] |-> (s4_prod_q <= PROD_MAX))
    else $error("risk product above limit");

  // half spread always at least one tick
  a_hs_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[2] |-> (s3_hs_q >= HS_ONE))
    else $error("half spread below one tick");
`endif

endmodule

FILE: dv/tb_market_maker_quote_engine.sv
// testbench for the market maker quote engine: directed and random quotes against a predictor
module tb_market_maker_quote_engine;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PX_FRAC = 8;
  localparam longint ONE_TICK = longint'(1) << mmqe_pkg::IFRAC;
  localparam logic [127:0] SKEW_CAP = 128'(1) << 60;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  mmqe_pkg::quote_in_t  in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  mmqe_pkg::quote_out_t out_data_o;
  logic                 cfg_we_i = 1'b0;
  logic [2:0]           cfg_idx_i = '0;
  logic [31:0]          cfg_wdata_i = '0;

  // register contents as the block should hold them
  mmqe_pkg::cfg_t       shadow_cfg;
  mmqe_pkg::quote_out_t quote_q[$];
  mmqe_pkg::quote_out_t due_quote;
  int                   mismatches = 0;
  int                   gap_pct = 0;
  int                   stall_pct = 0;
  int                   stall_hold = 0;

  market_maker_quote_engine #(
    .PRICE_FRAC_BITS(PX_FRAC)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  // idle length: mostly none or short, now and then long
  function automatic int pick_idle(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [31:0] clamp_tick(longint v);
    if (v > longint'(32'sh7fffffff)) return 32'sh7fffffff;
    if (v < -longint'(64'h80000000)) return 32'sh80000000;
    return v[31:0];
  endfunction

  // quote pair that one market update should produce under the current registers
  function automatic mmqe_pkg::quote_out_t quote_for(mmqe_pkg::quote_in_t q);
    mmqe_pkg::quote_out_t r;
    longint ref_px, half_sp, bid, ask, inv;
    longint unsigned t_rem, risk_term, mag, skew_mag, fh;
    logic [127:0] skew_full;
    inv = longint'(q.inventory);
    ref_px = longint'(64'(q.mid_px)) <<< (mmqe_pkg::IFRAC - PX_FRAC);
    if (shadow_cfg.pricing_mode == mmqe_pkg::MODE_AS) begin
      t_rem = (shadow_cfg.horizon > q.now_time) ?
              64'(shadow_cfg.horizon) - 64'(q.now_time) : 64'd0;
      risk_term = 64'(shadow_cfg.risk_coefficient) * t_rem;
      mag = (inv < 0) ? 64'(-inv) : 64'(inv);
      skew_full = 128'(mag) * 128'(risk_term);
      skew_mag = (skew_full > SKEW_CAP) ? 64'(SKEW_CAP) : skew_full[63:0];
      // a long position lowers the reference, a short one raises it
      if (inv < 0) ref_px = ref_px + longint'(skew_mag << 1);
      else ref_px = ref_px - longint'(skew_mag << 1);
      half_sp = longint'(risk_term + (64'(shadow_cfg.spread_floor_term) << 16));
    end else begin
      fh = (shadow_cfg.fixed_half_spread == 0) ? 64'd1 : 64'(shadow_cfg.fixed_half_spread);
      if (shadow_cfg.pricing_mode == mmqe_pkg::MODE_SKEW)
        ref_px = ref_px - inv * longint'(64'(shadow_cfg.skew_per_unit)) * 512;
      half_sp = longint'(fh << mmqe_pkg::IFRAC);
    end
    if (half_sp < ONE_TICK) half_sp = ONE_TICK;
    bid = (ref_px - half_sp) >>> mmqe_pkg::IFRAC;
    ask = -((-(ref_px + half_sp)) >>> mmqe_pkg::IFRAC);
    if (ask <= bid) ask = bid + 1;
    r.bid_price = clamp_tick(bid);
    r.ask_price = clamp_tick(ask);
    r.bid_enable = inv < longint'(64'(shadow_cfg.max_inventory));
    r.ask_enable = inv > -longint'(64'(shadow_cfg.max_inventory));
    r.quote_quantity = shadow_cfg.quote_size;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch in %s at %0t: got %0h, want %0h", what, $realtime, got, want);
    mismatches++;
  endtask

  // one market update, held until the transfer completes
  task automatic send_quote(mmqe_pkg::quote_in_t q);
    int gap;
    gap = pick_idle(gap_pct);
    if (gap > 0) begin
      if (in_valid_i) in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= q;
    do @(posedge clk_i); while (in_stall_o);
    quote_q.insert(quote_q.size(), quote_for(q));
  endtask

  task automatic send_fields(logic [31:0] mid, int inv, logic [31:0] now);
    mmqe_pkg::quote_in_t q;
    q.mid_px = mid;
    q.inventory = 24'(inv);
    q.now_time = now;
    send_quote(q);
  endtask

  // stop sending and wait for every quote in flight
  task automatic drain_quotes();
    if (in_valid_i) in_valid_i <= 1'b0;
    while (quote_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_reg(logic [2:0] idx, logic [31:0] val);
    drain_quotes();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      mmqe_pkg::CFG_PRICING_MODE:      shadow_cfg.pricing_mode = val[1:0];
      mmqe_pkg::CFG_FIXED_HALF_SPREAD: shadow_cfg.fixed_half_spread = val[15:0];
      mmqe_pkg::CFG_QUOTE_SIZE:        shadow_cfg.quote_size = val;
      mmqe_pkg::CFG_MAX_INVENTORY:     shadow_cfg.max_inventory = val[22:0];
      mmqe_pkg::CFG_SKEW_PER_UNIT:     shadow_cfg.skew_per_unit = val[23:0];
      mmqe_pkg::CFG_RISK_COEFFICIENT:  shadow_cfg.risk_coefficient = val[23:0];
      mmqe_pkg::CFG_SPREAD_FLOOR_TERM: shadow_cfg.spread_floor_term = val[23:0];
      default:                         shadow_cfg.horizon = val;
    endcase
    @(posedge clk_i);
  endtask

  // register value: zero, all ones, stray upper bits or a typical value
  function automatic logic [31:0] cfg_pick(int width, logic [31:0] typical);
    logic [31:0] mask;
    mask = 32'((64'(1) << width) - 1);
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return mask;
      2: return $urandom;
      default: return typical & mask;
    endcase
  endfunction

  // random market update shaped by the current registers
  function automatic mmqe_pkg::quote_in_t random_quote();
    mmqe_pkg::quote_in_t q;
    int lim, v;
    case ($urandom_range(0, 9))
      0: q.mid_px = 32'd0;
      1: q.mid_px = '1;
      default: q.mid_px = $urandom;
    endcase
    lim = int'(shadow_cfg.max_inventory);
    case ($urandom_range(0, 5))
      0, 1: begin
        v = lim - 2 + $urandom_range(0, 4);
        q.inventory = 24'($urandom_range(0, 1) ? -v : v);
      end
      2, 3: q.inventory = 24'(int'($urandom_range(0, 2000)) - 1000);
      default: q.inventory = 24'($urandom);
    endcase
    if (shadow_cfg.pricing_mode == mmqe_pkg::MODE_AS) begin
      case ($urandom_range(0, 3))
        0, 1: q.now_time = shadow_cfg.horizon - $urandom_range(0, 3000);
        2: q.now_time = shadow_cfg.horizon + $urandom_range(0, 100);
        default: q.now_time = $urandom;
      endcase
    end else begin
      q.now_time = $urandom;
    end
    return q;
  endfunction

  // compare each quote leaving the block with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (quote_q.size() == 0) begin
        report_mismatch("unexpected quote", out_data_o.bid_price, 0);
      end else begin
        due_quote = quote_q.pop_front();
        if (out_data_o.bid_price !== due_quote.bid_price)
          report_mismatch("bid_price", out_data_o.bid_price, due_quote.bid_price);
        if (out_data_o.ask_price !== due_quote.ask_price)
          report_mismatch("ask_price", out_data_o.ask_price, due_quote.ask_price);
        if (out_data_o.bid_enable !== due_quote.bid_enable)
          report_mismatch("bid_enable", out_data_o.bid_enable, due_quote.bid_enable);
        if (out_data_o.ask_enable !== due_quote.ask_enable)
          report_mismatch("ask_enable", out_data_o.ask_enable, due_quote.ask_enable);
        if (out_data_o.quote_quantity !== due_quote.quote_quantity)
          report_mismatch("quote_quantity", out_data_o.quote_quantity,
                          due_quote.quote_quantity);
      end
    end
  end

  // receiver back-pressure in bursts
  always @(posedge clk_i) begin
    if (stall_hold > 0) begin
      stall_hold--;
    end else begin
      stall_hold = pick_idle(stall_pct);
      out_stall_i <= (stall_hold > 0);
    end
  end

  // values left by reset, price and inventory extremes
  task automatic test_reset_defaults();
    gap_pct = 0;
    stall_pct = 0;
    send_fields(32'd0, 0, 32'd0);
    send_fields('1, -8388608, '1);
    send_fields(32'h0001_2380, 8388607, 32'd5);
    send_fields(32'h0000_6440, 100, 32'd0);
    send_fields(32'h0000_6440, -100, 32'd0);
    send_fields(32'h0000_6440, 99, 32'd0);
  endtask

  // fixed spread: zero spread raised to one tick, widest spread, unused mode code
  task automatic test_fixed_spread();
    gap_pct = 30;
    stall_pct = 30;
    set_reg(mmqe_pkg::CFG_FIXED_HALF_SPREAD, 32'd0);
    set_reg(mmqe_pkg::CFG_QUOTE_SIZE, 32'd0);
    send_fields(32'h0000_0180, 5, 32'd0);
    set_reg(mmqe_pkg::CFG_FIXED_HALF_SPREAD, 32'hffff);
    set_reg(mmqe_pkg::CFG_QUOTE_SIZE, 32'hffff_ffff);
    send_fields(32'd0, 0, 32'd0);
    send_fields('1, 1, 32'd0);
    set_reg(mmqe_pkg::CFG_PRICING_MODE, 32'd3);
    set_reg(mmqe_pkg::CFG_FIXED_HALF_SPREAD, 32'd7);
    send_fields(32'h0010_0055, -3, 32'd9);
  endtask

  // inventory skew, up to prices far outside 32 bits
  task automatic test_inventory_skew();
    set_reg(mmqe_pkg::CFG_PRICING_MODE, 32'(mmqe_pkg::MODE_SKEW));
    set_reg(mmqe_pkg::CFG_SKEW_PER_UNIT, 32'h0000_8000);
    set_reg(mmqe_pkg::CFG_MAX_INVENTORY, 32'd0);
    // zero inventory limit: a flat position quotes no side, quantity still reported
    send_fields(32'h0000_6400, 0, 32'd0);
    send_fields(32'h0000_6400, 3, 32'd0);
    set_reg(mmqe_pkg::CFG_SKEW_PER_UNIT, 32'hff_ffff);
    set_reg(mmqe_pkg::CFG_MAX_INVENTORY, 32'h7f_ffff);
    send_fields(32'h8000_0000, 8388607, 32'd0);
    send_fields(32'h8000_0000, -8388608, 32'd0);
  endtask

  // Avellaneda-Stoikov: normal skew, time past horizon, saturated skew
  task automatic test_avellaneda();
    set_reg(mmqe_pkg::CFG_PRICING_MODE, 32'(mmqe_pkg::MODE_AS));
    set_reg(mmqe_pkg::CFG_RISK_COEFFICIENT, 32'h0001_0000);
    set_reg(mmqe_pkg::CFG_SPREAD_FLOOR_TERM, 32'h0000_0280);
    set_reg(mmqe_pkg::CFG_HORIZON, 32'd1000);
    set_reg(mmqe_pkg::CFG_MAX_INVENTORY, 32'd50);
    send_fields(32'h0003_e800, 20, 32'd400);
    send_fields(32'h0003_e800, -50, 32'd999);
    send_fields(32'h0003_e800, 50, 32'd1000);
    send_fields(32'h0003_e800, -7, 32'd5000);
    set_reg(mmqe_pkg::CFG_RISK_COEFFICIENT, 32'hff_ffff);
    set_reg(mmqe_pkg::CFG_SPREAD_FLOOR_TERM, 32'hff_ffff);
    set_reg(mmqe_pkg::CFG_HORIZON, 32'hffff_ffff);
    send_fields(32'h4000_0000, -8388608, 32'd0);
    send_fields(32'h4000_0000, 8388607, 32'd0);
    send_fields('1, 0, 32'd0);
  endtask

  // random registers per phase, random updates inside each phase
  task automatic test_random_quotes();
    for (int phase = 0; phase < 9; phase++) begin
      gap_pct = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 30 : 70);
      stall_pct = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 70 : 30);
      if (phase == 0) begin
        for (int i = 0; i < 8; i++) set_reg(3'(i), 32'd0);
      end else if (phase == 1) begin
        for (int i = 0; i < 8; i++) set_reg(3'(i), 32'hffff_ffff);
      end else begin
        set_reg(mmqe_pkg::CFG_PRICING_MODE,
                $urandom_range(0, 1) ? 32'(mmqe_pkg::MODE_AS) : $urandom_range(0, 3));
        set_reg(mmqe_pkg::CFG_FIXED_HALF_SPREAD, cfg_pick(16, $urandom_range(1, 300)));
        set_reg(mmqe_pkg::CFG_QUOTE_SIZE, cfg_pick(32, $urandom));
        set_reg(mmqe_pkg::CFG_MAX_INVENTORY, cfg_pick(23, $urandom_range(0, 1000)));
        set_reg(mmqe_pkg::CFG_SKEW_PER_UNIT, cfg_pick(24, $urandom_range(0, 32'h4_0000)));
        set_reg(mmqe_pkg::CFG_RISK_COEFFICIENT,
                cfg_pick(24, $urandom_range(0, 32'h10_0000)));
        set_reg(mmqe_pkg::CFG_SPREAD_FLOOR_TERM,
                cfg_pick(24, $urandom_range(0, 32'h1_0000)));
        set_reg(mmqe_pkg::CFG_HORIZON, cfg_pick(32, $urandom));
      end
      repeat (50) send_quote(random_quote());
    end
  endtask

  initial begin
    shadow_cfg = '0;
    shadow_cfg.pricing_mode = mmqe_pkg::MODE_FIXED;
    shadow_cfg.fixed_half_spread = 16'd1;
    shadow_cfg.quote_size = 32'd1;
    shadow_cfg.max_inventory = 23'd100;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_fixed_spread();
    test_inventory_skew();
    test_avellaneda();
    test_random_quotes();
    drain_quotes();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/mmqe_pkg.sv
hw/rtl/mmqe_cfg_regs.sv
hw/rtl/market_maker_quote_engine.sv
dv/tb_market_maker_quote_engine.sv
